>>> hw/rtl/csl_pkg.sv
`default_nettype none
// ============================================================================
// csl_pkg: shared types, codes and character classes of the C subset lexer
// Holds the beat structs of both channels, the lexer mode and token class
// codes, and the character tests and keyword spellings used by the sequencer.
// ============================================================================
package csl_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 63;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] token_byte;
        logic [1:0] token_class;
        logic       last_of_token;
        logic       truncated;
    } out_beat_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WORD      = 2'd1,
        MODE_NUMBER    = 2'd2,
        MODE_DIRECTIVE = 2'd3
    } mode_t;

    localparam logic [1:0] CLASS_KEYWORD = 2'd0;
    localparam logic [1:0] CLASS_USER    = 2'd1;
    localparam logic [1:0] CLASS_NUMBER  = 2'd2;
    localparam logic [1:0] CLASS_SYMBOL  = 2'd3;

    localparam logic [7:0] CHAR_HASH       = 8'h23;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    function automatic logic is_letter(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_word_char(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || (b == CHAR_UNDERSCORE);
    endfunction

    // Printable, non-blank bytes that are neither letters nor digits.
    function automatic logic is_punct(input logic [7:0] b);
        return (b inside {[8'h21:8'h7E]}) && !is_letter(b) && !is_digit(b);
    endfunction

    // Spelling of "int", one byte per position.
    function automatic logic [7:0] kw_int_at(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h69;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Spelling of "return", one byte per position.
    function automatic logic [7:0] kw_return_at(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/csl_text_ram.sv
`default_nettype none
// ============================================================================
// csl_text_ram: token text buffer
// Simple dual-port memory, one write and one read port, read data registered.
// The read register holds while no read is made.
// ============================================================================
module csl_text_ram #(
    parameter int DEPTH  = csl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/c_subset_lexer_top.sv
`default_nettype none
// ============================================================================
// c_subset_lexer_top: byte-serial tokenizer for a small C subset
// Splits source text into word, keyword, number, directive and symbol tokens
// and sends each finished token out one byte per beat.
// ============================================================================
// Usage:
// The s_ channel carries one source byte per beat, or an end-of-input beat
// that flushes the pending token. The m_ channel carries one token byte per
// beat with its class, a last flag on the final byte and a truncated flag.
// Every input beat is latched and then processed in the following cycle; a
// byte that only extends the pending token is appended to it in the buffer.
// When a byte ends a token, the token text is read back from the text buffer
// one byte at a time (read, then load into the output register), and the
// ending byte is processed after the final byte has been loaded. The sequencer
// waits out the read latency of the text buffer before it issues the next
// read. Symbol tokens go straight to the output register. The output
// register decouples the two sides: a new beat is accepted while an earlier
// token byte still waits on m_ready. When the receiver stalls, emission stops
// with the text buffer read held and resumes without loss. Synchronous
// active-low reset returns the lexer to idle with an empty token; the text
// buffer needs no clearing.
// ============================================================================
module c_subset_lexer_top #(
    parameter int MAX_TOKEN_LEN = csl_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire csl_pkg::in_beat_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output csl_pkg::out_beat_t       m_data
);

    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_TOKEN_LEN);

    // ACCEPT waits for a beat, PROC handles the latched beat, READ and LOAD
    // walk the text buffer to send the pending token.
    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_PROC,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t              state_reg,   state_next;
    csl_pkg::in_beat_t   in_reg,      in_next;
    csl_pkg::mode_t      mode_reg,    mode_next;
    logic [LEN_W-1:0]    len_reg,     len_next;
    logic                ovf_reg,     ovf_next;
    logic                int_ok_reg,  int_ok_next;
    logic                ret_ok_reg,  ret_ok_next;
    logic [LEN_W-1:0]    idx_reg,     idx_next;
    logic [1:0]          cls_reg,     cls_next;
    logic                m_valid_reg, m_valid_next;
    csl_pkg::out_beat_t  out_reg,     out_next;

    logic              wr_en;
    logic              rd_en;
    logic [7:0]        rd_data;
    logic              do_append;
    logic              do_flush;
    logic              do_clear;
    logic              out_free;
    logic              is_last;
    logic              kw_match;
    logic [7:0]        cur_byte;

    // The buffer is written only in PROC and read only in READ, so a write
    // and a read of the same entry never overlap.
    csl_text_ram #(
        .DEPTH  (MAX_TOKEN_LEN),
        .ADDR_W (ADDR_W)
    ) u_text_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (in_reg.source_byte),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_ACCEPT);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign cur_byte = in_reg.source_byte;
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (idx_reg == len_reg - LEN_W'(1));
    assign kw_match = !ovf_reg && (((len_reg == LEN_W'(3)) && int_ok_reg) ||
                                   ((len_reg == LEN_W'(6)) && ret_ok_reg));

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        mode_next    = mode_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        int_ok_next  = int_ok_reg;
        ret_ok_next  = ret_ok_reg;
        idx_next     = idx_reg;
        cls_next     = cls_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        do_append    = 1'b0;
        do_flush     = 1'b0;
        do_clear     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ACCEPT: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                if (in_reg.end_of_input) begin
                    if (mode_reg != csl_pkg::MODE_IDLE && len_reg != '0) begin
                        do_flush = 1'b1;
                    end else begin
                        do_clear   = 1'b1;
                        state_next = ST_ACCEPT;
                    end
                end else if (((mode_reg == csl_pkg::MODE_WORD ||
                               mode_reg == csl_pkg::MODE_DIRECTIVE) &&
                              csl_pkg::is_word_char(cur_byte)) ||
                             (mode_reg == csl_pkg::MODE_NUMBER &&
                              csl_pkg::is_digit(cur_byte))) begin
                    do_append  = 1'b1;
                    state_next = ST_ACCEPT;
                end else if (mode_reg != csl_pkg::MODE_IDLE) begin
                    // The byte ends the token; it comes back here afterwards.
                    do_flush = 1'b1;
                end else if (csl_pkg::is_letter(cur_byte) ||
                             cur_byte == csl_pkg::CHAR_UNDERSCORE) begin
                    mode_next  = csl_pkg::MODE_WORD;
                    do_append  = 1'b1;
                    state_next = ST_ACCEPT;
                end else if (csl_pkg::is_digit(cur_byte)) begin
                    mode_next  = csl_pkg::MODE_NUMBER;
                    do_append  = 1'b1;
                    state_next = ST_ACCEPT;
                end else if (cur_byte == csl_pkg::CHAR_HASH) begin
                    mode_next  = csl_pkg::MODE_DIRECTIVE;
                    do_append  = 1'b1;
                    state_next = ST_ACCEPT;
                end else if (csl_pkg::is_punct(cur_byte)) begin
                    if (out_free) begin
                        m_valid_next           = 1'b1;
                        out_next.token_byte    = cur_byte;
                        out_next.token_class   = csl_pkg::CLASS_SYMBOL;
                        out_next.last_of_token = 1'b1;
                        out_next.truncated     = 1'b0;
                        state_next             = ST_ACCEPT;
                    end
                end else begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    out_next.token_byte    = rd_data;
                    out_next.token_class   = cls_reg;
                    out_next.last_of_token = is_last;
                    out_next.truncated     = ovf_reg;
                    if (is_last) begin
                        do_clear   = 1'b1;
                        state_next = ST_PROC;
                    end else begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase

        if (do_append) begin
            if (len_reg < LEN_W'(MAX_TOKEN_LEN)) begin
                wr_en       = 1'b1;
                len_next    = len_reg + LEN_W'(1);
                int_ok_next = int_ok_reg && (len_reg < LEN_W'(3)) &&
                              (cur_byte == csl_pkg::kw_int_at(len_reg[2:0]));
                ret_ok_next = ret_ok_reg && (len_reg < LEN_W'(6)) &&
                              (cur_byte == csl_pkg::kw_return_at(len_reg[2:0]));
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (do_flush) begin
            idx_next   = '0;
            state_next = ST_READ;
            case (mode_reg)
                csl_pkg::MODE_NUMBER:    cls_next = csl_pkg::CLASS_NUMBER;
                csl_pkg::MODE_DIRECTIVE: cls_next = csl_pkg::CLASS_KEYWORD;
                default: begin
                    cls_next = kw_match ? csl_pkg::CLASS_KEYWORD
                                        : csl_pkg::CLASS_USER;
                end
            endcase
        end

        if (do_clear) begin
            mode_next   = csl_pkg::MODE_IDLE;
            len_next    = '0;
            ovf_next    = 1'b0;
            int_ok_next = 1'b1;
            ret_ok_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            mode_reg    <= csl_pkg::MODE_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            int_ok_reg  <= 1'b1;
            ret_ok_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            int_ok_reg  <= int_ok_next;
            ret_ok_reg  <= ret_ok_next;
            m_valid_reg <= m_valid_next;
        end
        in_reg  <= in_next;
        idx_reg <= idx_next;
        cls_reg <= cls_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // An idle lexer never holds token text.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == csl_pkg::MODE_IDLE) |-> (len_reg == '0))
        else $error("idle lexer holds token text");

    // Bytes are only dropped once the buffer is full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == LEN_W'(MAX_TOKEN_LEN)))
        else $error("overflow flagged before the buffer is full");

    // A symbol beat is a complete, untruncated one-byte token.
    a_symbol_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.token_class == csl_pkg::CLASS_SYMBOL) |->
        (m_data.last_of_token && !m_data.truncated))
        else $error("symbol beat is not a single untruncated byte");

    // Every read of the buffer is followed by the load of its data.
    a_read_load: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> (state_reg == ST_LOAD))
        else $error("buffer read not followed by a load");
`endif

endmodule
`default_nettype wire
